// File: design/wellp_pkg.sv
package wellp_pkg;

    // Ring geometry and generator taps
    localparam int RING_DEPTH     = 16;
    localparam int TAP_C          = 13;
    localparam int TAP_E          = 9;
    localparam int TAP_W          = RING_DEPTH - 1;
    localparam int MAX_LANES      = 8;
    localparam int SEED_MAX_WORDS = RING_DEPTH * MAX_LANES;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_RUN = 16;
    localparam int DEF_LANES   = 4;

    // Word and field widths
    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 23;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int SPAN_W    = WORD_W + 1;
    localparam int PROD_W    = SPAN_W + FRAC_W + 1;

    // Generator constants
    localparam logic [WORD_W-1:0] MIX_MASK   = 32'hda442d24;
    localparam logic [WORD_W-1:0] SEED_START = 32'd5489;
    localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;

    localparam logic signed [WORD_W-1:0] RANGE_LOW_RST  = 32'sd0;
    localparam logic signed [WORD_W-1:0] RANGE_HIGH_RST = 32'sd65536;
    localparam logic signed [SPAN_W-1:0] SPAN_RST       = 33'sd65536;

    // Channel words
    typedef struct packed {
        logic [COUNT_W-1:0] sample_count;
    } req_word_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] sample;
        logic                     last_of_run;
    } smp_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [WORD_W-1:0]    data;
    } cfg_word_t;

    // Issued fraction between sequencer and scaler
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [FRAC_W-1:0] frac;
    } frac_word_t;

    // Seed words from the Mersenne-style recurrence; evaluated at elaboration
    function automatic logic [SEED_MAX_WORDS*WORD_W-1:0] seed_table();
        logic [WORD_W-1:0]                x;
        logic [SEED_MAX_WORDS*WORD_W-1:0] t;
        x = SEED_START;
        t = '0;
        t[WORD_W-1:0] = x;
        for (int k = 1; k < SEED_MAX_WORDS; k++)
        begin
            x = WORD_W'(SEED_MULT * (x ^ (x >> 30))) + WORD_W'(k);
            t[k*WORD_W +: WORD_W] = x;
        end
        return t;
    endfunction

endpackage

// File: design/wellp_chan_if.sv
interface wellp_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/wellp_ring.sv
module wellp_ring #(
    parameter int LANES = wellp_pkg::DEF_LANES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    output logic [wellp_pkg::FRAC_W-1:0]  fracs [LANES]
);
    localparam int W = wellp_pkg::WORD_W;
    localparam int D = wellp_pkg::RING_DEPTH;
    localparam logic [wellp_pkg::SEED_MAX_WORDS*W-1:0] SEED_WORDS = wellp_pkg::seed_table();

    // Ring kept relative to the current position: entry 0 is the position
    logic [W-1:0] ring_reg [D][LANES];
    logic [W-1:0] r0 [LANES];
    logic [W-1:0] r1 [LANES];

    // One WELL512a step per lane
    always_comb
    begin
        logic [W-1:0] a, c, e, w, b, f, d;
        for (int l = 0; l < LANES; l++)
        begin
            a = ring_reg[0][l];
            c = ring_reg[wellp_pkg::TAP_C][l];
            e = ring_reg[wellp_pkg::TAP_E][l];
            w = ring_reg[wellp_pkg::TAP_W][l];
            b = a ^ (a << 16) ^ c ^ (c << 15);
            f = e ^ (e >> 11);
            r0[l] = b ^ f;
            d = r0[l] ^ ((r0[l] << 5) & wellp_pkg::MIX_MASK);
            r1[l] = w ^ (w << 2) ^ b ^ (b << 18) ^ (f << 28) ^ d;
            fracs[l] = r1[l][wellp_pkg::FRAC_W-1:0];
        end
    end

    // Rotate by one on a step: the new position is the old position + 15
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < D; j++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    ring_reg[j][l] <= SEED_WORDS[(j*LANES+l)*W +: W];
                end
            end
        end
        else if (step)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                for (int j = 2; j < D; j++)
                begin
                    ring_reg[j][l] <= ring_reg[j-1][l];
                end
                ring_reg[1][l] <= r0[l];
                ring_reg[0][l] <= r1[l];
            end
        end
    end

endmodule

// File: design/wellp_seq.sv
module wellp_seq #(
    parameter int MAX_RUN = wellp_pkg::DEF_MAX_RUN,
    parameter int LANES   = wellp_pkg::DEF_LANES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    wellp_chan_if.sink                   request,
    input  logic                         advance,
    input  logic [wellp_pkg::FRAC_W-1:0] fracs [LANES],
    output logic                         step,
    output wellp_pkg::frac_word_t        issued
);
    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam int BN_W  = $clog2(LANES + 1);
    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_after;
    logic [CNT_W-1:0] pend_cnt_reg, pend_cnt_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [BN_W-1:0]  bn_reg, bn_next;
    logic [wellp_pkg::FRAC_W-1:0] batch_reg [LANES];
    logic                         issued_valid_reg;
    logic                         issued_last_reg;
    logic [wellp_pkg::FRAC_W-1:0] issued_frac_reg;

    logic                         accept;
    logic                         issue;
    logic                         empty;
    logic [CNT_W-1:0]             req_cnt;
    logic [31:0]                  count_wide;
    logic [wellp_pkg::FRAC_W-1:0] frac_sel;

    // Take a request whenever the holding slot is free
    assign request.ready = !pend_valid_reg;
    assign accept        = request.valid && request.ready;

    // Saturate the requested count to the run limit
    always_comb
    begin
        count_wide = 32'(request.payload.sample_count);
        if (count_wide > 32'(MAX_RUN))
            req_cnt = CNT_W'(MAX_RUN);
        else
            req_cnt = CNT_W'(count_wide);
    end

    // Issue one fraction per advancing cycle; refill the batch when it runs dry
    always_comb
    begin
        issue     = advance && (cnt_reg != '0);
        empty     = (bn_reg == BN_W'(LANES));
        step      = issue && empty;
        frac_sel  = empty ? fracs[0] : batch_reg[bn_reg[IDX_W-1:0]];
        cnt_after = issue ? cnt_reg - CNT_W'(1) : cnt_reg;
    end

    // Next count and holding slot
    always_comb
    begin
        cnt_next        = cnt_after;
        pend_cnt_next   = pend_cnt_reg;
        pend_valid_next = pend_valid_reg;
        priority if (pend_valid_reg && (cnt_after == '0))
        begin
            cnt_next        = pend_cnt_reg;
            pend_valid_next = 1'b0;
        end
        else if (accept && (req_cnt != '0))
        begin
            if (cnt_after == '0)
                cnt_next = req_cnt;
            else
            begin
                pend_valid_next = 1'b1;
                pend_cnt_next   = req_cnt;
            end
        end
    end

    // Batch read pointer
    always_comb
    begin
        bn_next = bn_reg;
        if (issue)
            bn_next = empty ? BN_W'(1) : bn_reg + BN_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            bn_reg           <= BN_W'(LANES);
            issued_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            bn_reg         <= bn_next;
            if (advance)
                issued_valid_reg <= issue;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_cnt_reg <= pend_cnt_next;
        if (step)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                batch_reg[l] <= fracs[l];
            end
        end
        if (advance)
        begin
            issued_frac_reg <= frac_sel;
            issued_last_reg <= (cnt_reg == CNT_W'(1));
        end
    end

    assign issued = '{valid: issued_valid_reg, last: issued_last_reg, frac: issued_frac_reg};

    // The batch pointer never runs past the batch
    a_bn_range: assert property (@(posedge clk) disable iff (!rst_n)
        bn_reg <= BN_W'(LANES))
        else $error("batch pointer out of range");

    // A refill hands out lane 0 and leaves the pointer on lane 1
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> bn_reg == BN_W'(1))
        else $error("batch pointer wrong after refill");

    // The remaining count stays within the run limit
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RUN))
        else $error("run count exceeds limit");

endmodule

// File: design/wellp_scale.sv
module wellp_scale (
    input  logic                  clk,
    input  logic                  rst_n,
    wellp_chan_if.sink            cfg,
    wellp_chan_if.source          result,
    input  wellp_pkg::frac_word_t issued,
    output logic                  advance
);
    localparam int W = wellp_pkg::WORD_W;
    localparam int F = wellp_pkg::FRAC_W;
    localparam int P = wellp_pkg::PROD_W;

    logic signed [W-1:0]                 low_reg, high_reg;
    logic signed [wellp_pkg::SPAN_W-1:0] span_reg;
    logic signed [wellp_pkg::PROD_W-1:0] prod_reg;
    logic                                prod_valid_reg, prod_last_reg;
    logic                                out_valid_reg;
    wellp_pkg::smp_word_t                out_reg;
    logic                                cfg_write;
    logic signed [W-1:0]                 cfg_data;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;
    assign cfg_data  = $signed(cfg.payload.data);

    // Hold the bounds and keep the span up to date on each write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= wellp_pkg::RANGE_LOW_RST;
            high_reg <= wellp_pkg::RANGE_HIGH_RST;
            span_reg <= wellp_pkg::SPAN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg.payload.index)
                wellp_pkg::REG_RANGE_LOW:
                begin
                    low_reg  <= cfg_data;
                    span_reg <= {high_reg[W-1], high_reg} - {cfg_data[W-1], cfg_data};
                end
                wellp_pkg::REG_RANGE_HIGH:
                begin
                    high_reg <= cfg_data;
                    span_reg <= {cfg_data[W-1], cfg_data} - {low_reg[W-1], low_reg};
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pipeline moves while the output register is free or being drained
    assign advance = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            prod_valid_reg <= issued.valid;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    // Multiply span by fraction, then floor-shift and add the lower bound
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg            <= P'(span_reg) * P'($signed({1'b0, issued.frac}));
            prod_last_reg       <= issued.last;
            out_reg.sample      <= low_reg + $signed(prod_reg[F+W-1:F]);
            out_reg.last_of_run <= prod_last_reg;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

endmodule

// File: design/well512_four_lane_uniform_generator.sv
// Four WELL512a lanes step in lockstep over a 16-entry ring seeded from 5489
// and hand out one scaled sample, low + floor((high - low) * f / 2^23) in
// signed Q16.16, per clock cycle while the output is not stalled. A request
// for n samples (1 to MAX_RUN, larger counts saturate, zero yields nothing)
// yields n samples; unused fractions of a batch carry over to the next
// request. The sample sequencer issues one fraction a cycle while the
// pipeline advances, stepping the ring in the same cycle when its batch is
// empty; the first sample of a request passes through the count, fraction,
// product and output registers. One further request is held while a run is
// in progress, so consecutive runs leave no gap. Configuration writes are
// taken at once and must be made only while no run is in progress.
module well512_four_lane_uniform_generator #(
    parameter int MAX_RUN = wellp_pkg::DEF_MAX_RUN,
    parameter int LANES   = wellp_pkg::DEF_LANES
) (
    input  logic         clk,
    input  logic         rst_n,
    wellp_chan_if.sink   request,
    wellp_chan_if.sink   cfg,
    wellp_chan_if.source result
);
    logic                         step;
    logic                         advance;
    logic [wellp_pkg::FRAC_W-1:0] fracs [LANES];
    wellp_pkg::frac_word_t        issued;

    wellp_ring #(
        .LANES (LANES)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .fracs (fracs)
    );

    wellp_seq #(
        .MAX_RUN (MAX_RUN),
        .LANES   (LANES)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .advance (advance),
        .fracs   (fracs),
        .step    (step),
        .issued  (issued)
    );

    wellp_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .result  (result),
        .issued  (issued),
        .advance (advance)
    );

endmodule

// File: verif/well_sample_checker.sv
module well_sample_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_ready,
    input  wellp_pkg::req_word_t req_word,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  wellp_pkg::cfg_word_t cfg_word,
    input  logic                 smp_valid,
    input  logic                 smp_ready,
    input  wellp_pkg::smp_word_t smp_word,
    output int                   mismatches,
    output int                   samples_waiting,
    output int                   samples_checked
);

    localparam int WORD_W       = wellp_pkg::WORD_W;
    localparam int FRAC_W       = wellp_pkg::FRAC_W;
    localparam int COUNT_W      = wellp_pkg::COUNT_W;
    localparam int RING_DEPTH   = wellp_pkg::RING_DEPTH;
    localparam int LANE_COUNT   = wellp_pkg::DEF_LANES;
    localparam int RUN_CAP      = wellp_pkg::DEF_MAX_RUN;
    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the generator state and the range registers
    logic [WORD_W-1:0]        ring [RING_DEPTH*LANE_COUNT];
    logic [3:0]               ring_pos;
    logic [FRAC_W-1:0]        batch [LANE_COUNT];
    int                       batch_next;
    logic signed [WORD_W-1:0] lo_bound;
    logic signed [WORD_W-1:0] hi_bound;
    wellp_pkg::smp_word_t     expected_samples [$];
    int                       reported;

    // Seed the ring by the multiplicative recurrence and restore register defaults
    function automatic void seed_ring();
        logic [WORD_W-1:0] x;
        x = wellp_pkg::SEED_START;
        ring[0] = x;
        for (int k = 1; k < RING_DEPTH * LANE_COUNT; k++)
        begin
            x = wellp_pkg::SEED_MULT * (x ^ (x >> 30)) + WORD_W'(k);
            ring[k] = x;
        end
        ring_pos   = '0;
        batch_next = LANE_COUNT;
        foreach (batch[i])
            batch[i] = '0;
        lo_bound = wellp_pkg::RANGE_LOW_RST;
        hi_bound = wellp_pkg::RANGE_HIGH_RST;
        expected_samples.delete();
    endfunction

    // Advance every lane by one WELL512a step and refill the batch
    function automatic void step_ring();
        logic [3:0]        p0, p9, p13, p15;
        logic [WORD_W-1:0] a, c, e, w, b, f, r0, d, r1;
        p0  = ring_pos;
        p9  = p0 + 4'(wellp_pkg::TAP_E);
        p13 = p0 + 4'(wellp_pkg::TAP_C);
        p15 = p0 + 4'(wellp_pkg::TAP_W);
        for (int lane = 0; lane < LANE_COUNT; lane++)
        begin
            a  = ring[p0 * LANE_COUNT + lane];
            c  = ring[p13 * LANE_COUNT + lane];
            e  = ring[p9 * LANE_COUNT + lane];
            w  = ring[p15 * LANE_COUNT + lane];
            b  = a ^ (a << 16) ^ c ^ (c << 15);
            f  = e ^ (e >> 11);
            r0 = b ^ f;
            d  = r0 ^ ((r0 << 5) & wellp_pkg::MIX_MASK);
            r1 = w ^ (w << 2) ^ b ^ (b << 18) ^ (f << 28) ^ d;
            ring[p0 * LANE_COUNT + lane]  = r0;
            ring[p15 * LANE_COUNT + lane] = r1;
            batch[lane] = r1[FRAC_W-1:0];
        end
        ring_pos   = p15;
        batch_next = 0;
    endfunction

    // low + floor(span * frac / 2^23), span taken at full width
    function automatic logic signed [WORD_W-1:0] scale_to_range(logic [FRAC_W-1:0] frac);
        longint span;
        longint frac_wide;
        longint prod;
        span      = longint'(hi_bound) - longint'(lo_bound);
        frac_wide = longint'(frac);
        prod      = span * frac_wide;
        return WORD_W'(longint'(lo_bound) + (prod >>> FRAC_W));
    endfunction

    // Queue the samples one request produces; oversized counts saturate
    function automatic void predict_run(logic [COUNT_W-1:0] count);
        int                   n;
        wellp_pkg::smp_word_t s;
        n = (count > RUN_CAP) ? RUN_CAP : int'(count);
        for (int k = 0; k < n; k++)
        begin
            if (batch_next >= LANE_COUNT)
                step_ring();
            s.sample      = scale_to_range(batch[batch_next]);
            s.last_of_run = (k == n - 1);
            batch_next++;
            expected_samples.push_back(s);
        end
    endfunction

    // Compare one delivered word with the oldest expectation
    function automatic void check_sample(wellp_pkg::smp_word_t got);
        wellp_pkg::smp_word_t want;
        samples_checked++;
        if (expected_samples.size() == 0)
        begin
            mismatches++;
            if (reported < REPORT_LIMIT)
                $display("unexpected sample word: sample=%0d last=%0b",
                         got.sample, got.last_of_run);
            reported++;
        end
        else
        begin
            want = expected_samples.pop_front();
            if (got.sample !== want.sample || got.last_of_run !== want.last_of_run)
            begin
                mismatches++;
                if (reported < REPORT_LIMIT)
                    $display("sample %0d mismatch: sample exp %0d got %0d, last exp %0b got %0b",
                             samples_checked, want.sample, got.sample,
                             want.last_of_run, got.last_of_run);
                reported++;
            end
        end
    endfunction

    // Track config writes, requests and delivered words at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_ring();
            mismatches      = 0;
            samples_checked = 0;
            reported        = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_word.index == wellp_pkg::REG_RANGE_LOW)
                    lo_bound = cfg_word.data;
                else if (cfg_word.index == wellp_pkg::REG_RANGE_HIGH)
                    hi_bound = cfg_word.data;
            end
            if (req_valid && req_ready)
                predict_run(req_word.sample_count);
            if (smp_valid && smp_ready)
                check_sample(smp_word);
        end
        samples_waiting = expected_samples.size();
    end

endmodule

// File: verif/tb.sv
module tb;

    localparam int WORD_W    = wellp_pkg::WORD_W;
    localparam int COUNT_W   = wellp_pkg::COUNT_W;
    localparam int CFG_IDX_W = wellp_pkg::CFG_IDX_W;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int CHUNKS_PER_PHASE = 4;
    localparam int REQS_PER_CHUNK = 42;

    // Indexes outside the register map; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int src_idle_pct = 8;
    int sink_idle_pct = 64;
    int holdoff_req = 0;
    int requests_sent = 0;
    int range_settings = 0;

    int mismatches;
    int samples_waiting;
    int samples_checked;

    int unsigned directed_counts [11] = '{1, 2, 3, 4, 5, 16, 17, 31, 0, 8, 7};

    wellp_chan_if #(.payload_t(wellp_pkg::req_word_t)) req_ch ();
    wellp_chan_if #(.payload_t(wellp_pkg::cfg_word_t)) cfg_ch ();
    wellp_chan_if #(.payload_t(wellp_pkg::smp_word_t)) smp_ch ();

    well512_four_lane_uniform_generator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .cfg     (cfg_ch),
        .result  (smp_ch)
    );

    well_sample_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_ch.valid),
        .req_ready       (req_ch.ready),
        .req_word        (req_ch.payload),
        .cfg_valid       (cfg_ch.valid),
        .cfg_ready       (cfg_ch.ready),
        .cfg_word        (cfg_ch.payload),
        .smp_valid       (smp_ch.valid),
        .smp_ready       (smp_ch.ready),
        .smp_word        (smp_ch.payload),
        .mismatches      (mismatches),
        .samples_waiting (samples_waiting),
        .samples_checked (samples_checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Drive sample ready: random stalls, or a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        smp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_req > 0)
            begin
                hold_left   = holdoff_req;
                holdoff_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                smp_ch.ready <= 1'b0;
            end
            else
                smp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Abort when no word moves on any channel for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
                || (smp_ch.valid && smp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one request word, with random idle cycles ahead of it
    task automatic send_request(input logic [COUNT_W-1:0] count);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload.sample_count <= count;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [WORD_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload.index <= index;
        cfg_ch.payload.data <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_range(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        write_reg(wellp_pkg::REG_RANGE_LOW, lo);
        write_reg(wellp_pkg::REG_RANGE_HIGH, hi);
        range_settings++;
    endtask

    // Drop valid, wait for every expected sample, then let the pipeline empty
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (samples_waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Change idling away from the falling edge so the ready process sees it cleanly
    task automatic set_idling(input int src_pct, input int sink_pct, input int hold);
        @(posedge clk);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        holdoff_req   = hold;
        @(negedge clk);
    endtask

    function automatic logic [COUNT_W-1:0] random_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return COUNT_W'($urandom_range(17, 31));
        if (roll < 40)
            return COUNT_W'($urandom_range(1, 4));
        return COUNT_W'($urandom_range(1, wellp_pkg::DEF_MAX_RUN));
    endfunction

    // Pick a range: wide, narrow, reversed or empty; sometimes poke spare indexes
    task automatic pick_range();
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        lo = $urandom();
        case ($urandom_range(0, 4))
            0: hi = $urandom();
            1: hi = lo + WORD_W'($urandom_range(1, 1 << 20));
            2: hi = lo - WORD_W'($urandom_range(1, 1 << 20));
            3: hi = lo;
            default:
            begin
                lo = WORD_W'($urandom_range(0, 1 << 16)) << 16;
                hi = lo + (WORD_W'($urandom_range(1, 255)) << 16);
            end
        endcase
        write_range(lo, hi);
        if ($urandom_range(0, 3) == 0)
            write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, $urandom());
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;

        // Hold reset, then release
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed runs on the reset range: batch carry-over, saturation, zero count
        foreach (directed_counts[i])
            send_request(COUNT_W'(directed_counts[i]));
        settle();

        // Widest span
        write_range(32'h8000_0000, 32'h7fff_ffff);
        send_request(5'd16);
        send_request(5'd5);
        send_request(5'd3);
        settle();

        // Reversed range at the extremes
        write_range(32'h7fff_ffff, 32'h8000_0000);
        send_request(5'd16);
        send_request(5'd4);
        settle();

        // Empty range, then writes to unmapped indexes that must not stick
        write_range(32'h0012_3456, 32'h0012_3456);
        write_reg(REG_SPARE_A, 32'hffff_ffff);
        write_reg(REG_SPARE_B, 32'h5555_aaaa);
        send_request(5'd6);
        settle();

        // Random phases: sender idles lightly, then receiver, then neither
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: set_idling(8, 64, 0);
                1: set_idling(64, 8, 0);
                default: set_idling(0, 0, 0);
            endcase
            for (int chunk = 0; chunk < CHUNKS_PER_PHASE; chunk++)
            begin
                pick_range();
                if (phase == 2 && chunk == 0)
                    set_idling(0, 0, HOLDOFF_CYCLES);
                repeat (REQS_PER_CHUNK) send_request(random_count());
                settle();
            end
        end

        $display("Sent %0d requests over %0d range settings; checked %0d samples.",
                 requests_sent, range_settings, samples_checked);
        $display("Idling covered both sides, no idling, and a long output hold-off.");
        if (mismatches == 0 && samples_waiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
design/wellp_pkg.sv
design/wellp_chan_if.sv
design/wellp_ring.sv
design/wellp_seq.sv
design/wellp_scale.sv
design/well512_four_lane_uniform_generator.sv
verif/well_sample_checker.sv
verif/tb.sv
